### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define TSG_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// When the antecedent holds, the consequent holds in the next cycle.
`define TSG_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/tsg_pkg.sv
// ----------------------------------------------------------------------------
// Triangle span generator package
// Field layouts, register indexes and codes shared by the block and checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tsg_pkg;

	localparam int DIM_W      = 14;
	localparam int POS_W      = 13;
	localparam int COLOR_W    = 32;
	localparam int IN_COORD_W = 16;
	localparam int CFG_IDX_W  = 2;

	localparam logic [DIM_W-1:0] DIM_MAX      = 14'd8192;
	localparam logic [DIM_W-1:0] WIDTH_RESET  = 14'd1024;
	localparam logic [DIM_W-1:0] HEIGHT_RESET = 14'd768;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_TICK = 1'b1;

	localparam logic KIND_SPAN   = 1'b0;
	localparam logic KIND_UPDATE = 1'b1;

	// Input request payload, first member is the top bits.
	typedef struct packed {
		logic [COLOR_W-1:0]    ccolor;
		logic [IN_COORD_W-1:0] cy;
		logic [IN_COORD_W-1:0] cx;
		logic [COLOR_W-1:0]    bcolor;
		logic [IN_COORD_W-1:0] by;
		logic [IN_COORD_W-1:0] bx;
		logic [COLOR_W-1:0]    acolor;
		logic [IN_COORD_W-1:0] ay;
		logic [IN_COORD_W-1:0] ax;
	} in_data_t;

	// Result payload, padded to whole bytes.
	typedef struct packed {
		logic [1:0]         pad;
		logic [DIM_W-1:0]   rect_h;
		logic [DIM_W-1:0]   rect_w;
		logic [POS_W-1:0]   rect_y;
		logic [POS_W-1:0]   rect_x;
		logic [COLOR_W-1:0] fill_color;
	} out_data_t;

	localparam int IN_DATA_W  = $bits(in_data_t);
	localparam int OUT_DATA_W = $bits(out_data_t);

	// Frame dimension as used: zero acts as one, anything above the maximum as the maximum.
	function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] r);
		logic [DIM_W-1:0] d;
		if (r == '0) begin
			d = DIM_W'(1);
		end else if (r > DIM_MAX) begin
			d = DIM_MAX;
		end else begin
			d = r;
		end
		return d;
	endfunction

endpackage

### hdl/triangle_scanline_span_generator_top.sv
// ----------------------------------------------------------------------------
// Triangle scanline span generator
// A load request finishes in its accept cycle. A tick that yields a span holds
// s_axis_tready low while the left and right edge divisions run one after the other in
// the shared divider, and the span becomes valid as ready returns. A flat edge skips its
// division, a line off the frame sideways skips the emit state and an update tick goes
// straight to the emit state; a stalled output register stretches the wait. Reset clears
// all state; frame registers come up at 1024 x 768.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module triangle_scanline_span_generator_top #(
	parameter int MAX_SPANS  = 768,
	parameter int COORD_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// Input requests
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// ax, ay, acolor, bx, by, bcolor, cx, cy, ccolor (lowest bit up)
	input  logic [tsg_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	// action
	input  logic                           s_axis_tuser,
	// Result requests
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// fill_color, rect_x, rect_y, rect_w, rect_h, two zero pad bits (lowest bit up)
	output logic [tsg_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	// kind
	output logic                           m_axis_tuser,
	output logic                           m_axis_tlast,
	// Configuration writes
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [tsg_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tsg_pkg::DIM_W-1:0]      cfg_data
);

	// Coordinate width, the widths of edge arithmetic and of the compare domain.
	localparam int CB   = COORD_BITS;
	localparam int XW   = CB + 2;
	localparam int KW   = CB + 4;
	localparam int QW   = CB + 1;
	localparam int PW   = 2 * CB + 1;
	localparam int CNTW = $clog2(QW);
	localparam int SCW  = $clog2(MAX_SPANS + 1);

	localparam logic [CNTW-1:0] DIV_LAST = CNTW'(QW - 1);

	localparam logic EDGE_LEFT  = 1'b0;
	localparam logic EDGE_RIGHT = 1'b1;

	typedef logic signed [CB-1:0] coord_t;
	typedef logic signed [XW-1:0] xpos_t;
	typedef logic signed [KW-1:0] wide_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_ADD,
		ST_FIN,
		ST_EMIT
	} state_t;

	state_t state_q;

	// Frame registers.
	logic [tsg_pkg::DIM_W-1:0] width_q;
	logic [tsg_pkg::DIM_W-1:0] height_q;

	// Triangle held between ticks: sorted vertices, top color, line range and box.
	coord_t                      x0_q, x1_q, x2_q;
	coord_t                      y0_q, y1_q, y2_q;
	logic [tsg_pkg::COLOR_W-1:0] color_q;
	logic [tsg_pkg::DIM_W-1:0]   line_q;
	logic [tsg_pkg::POS_W-1:0]   first_q;
	logic [tsg_pkg::POS_W-1:0]   final_q;
	logic [SCW-1:0]              cnt_q;
	xpos_t                       bmin_q;
	xpos_t                       bmax_q;
	logic                        scan_q;

	// Working registers of the shared multiply and divide unit.
	logic [tsg_pkg::POS_W-1:0] ywork_q;
	logic                      edge_q;
	coord_t                    xa_q;
	logic [CB-1:0]             den_q;
	logic                      neg_q;
	logic [CB-1:0]             rem_q;
	logic [QW-1:0]             quo_q;
	logic [CNTW-1:0]           div_cnt_q;
	xpos_t                     lx_q;
	xpos_t                     rx_q;

	// Result waiting for the output register, and the output register.
	tsg_pkg::out_data_t pend_q;
	logic               pend_kind_q;
	logic               pend_last_q;
	tsg_pkg::out_data_t od_q;
	logic               okind_q;
	logic               olast_q;
	logic               out_valid_q;

	tsg_pkg::in_data_t in_d;

	assign in_d          = s_axis_tdata;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = od_q;
	assign m_axis_tuser  = okind_q;
	assign m_axis_tlast  = olast_q;

	// ------------------------------------------------------------------
	// Load: sort the three vertices by y with three compare-and-swap steps.
	// Each swap happens only when the upper y is strictly greater, but equal
	// y values may still change order. The line range is clipped to the frame.
	// ------------------------------------------------------------------
	coord_t                      ld_x [3];
	coord_t                      ld_y [3];
	logic [tsg_pkg::COLOR_W-1:0] ld_c [3];
	logic                        ld_discard;
	logic [tsg_pkg::POS_W-1:0]   ld_first;
	logic [tsg_pkg::POS_W-1:0]   ld_final;
	logic [tsg_pkg::DIM_W-1:0]   hgt;

	always_comb begin
		coord_t                      tx;
		coord_t                      ty;
		logic [tsg_pkg::COLOR_W-1:0] tc;
		wide_t                       y0k;
		wide_t                       y2k;
		wide_t                       hk;

		tx  = '0;
		ty  = '0;
		tc  = '0;
		hgt = tsg_pkg::eff_dim(height_q);

		// Coordinates are the low COORD_BITS of the field, sign-extended.
		ld_x[0] = coord_t'(CB'(in_d.ax));
		ld_y[0] = coord_t'(CB'(in_d.ay));
		ld_c[0] = in_d.acolor;
		ld_x[1] = coord_t'(CB'(in_d.bx));
		ld_y[1] = coord_t'(CB'(in_d.by));
		ld_c[1] = in_d.bcolor;
		ld_x[2] = coord_t'(CB'(in_d.cx));
		ld_y[2] = coord_t'(CB'(in_d.cy));
		ld_c[2] = in_d.ccolor;

		if (ld_y[0] > ld_y[1]) begin
			tx = ld_x[0]; ld_x[0] = ld_x[1]; ld_x[1] = tx;
			ty = ld_y[0]; ld_y[0] = ld_y[1]; ld_y[1] = ty;
			tc = ld_c[0]; ld_c[0] = ld_c[1]; ld_c[1] = tc;
		end
		if (ld_y[0] > ld_y[2]) begin
			tx = ld_x[0]; ld_x[0] = ld_x[2]; ld_x[2] = tx;
			ty = ld_y[0]; ld_y[0] = ld_y[2]; ld_y[2] = ty;
			tc = ld_c[0]; ld_c[0] = ld_c[2]; ld_c[2] = tc;
		end
		if (ld_y[1] > ld_y[2]) begin
			tx = ld_x[1]; ld_x[1] = ld_x[2]; ld_x[2] = tx;
			ty = ld_y[1]; ld_y[1] = ld_y[2]; ld_y[2] = ty;
			tc = ld_c[1]; ld_c[1] = ld_c[2]; ld_c[2] = tc;
		end

		y0k = wide_t'(ld_y[0]);
		y2k = wide_t'(ld_y[2]);
		hk  = wide_t'(hgt);

		// Entirely above the frame or entirely below it.
		ld_discard = (y2k < 0) || (y0k >= hk);
		ld_first   = (y0k < 0) ? '0 : y0k[tsg_pkg::POS_W-1:0];
		ld_final   = (y2k >= hk) ? tsg_pkg::POS_W'(hgt - tsg_pkg::DIM_W'(1))
		                         : y2k[tsg_pkg::POS_W-1:0];
	end

	// ------------------------------------------------------------------
	// Tick: decide whether the walk is over and build the update rectangle.
	// The box is clamped into the frame, so its width is at least one.
	// ------------------------------------------------------------------
	logic [tsg_pkg::DIM_W-1:0] wid;
	wide_t                     wid_k;
	wide_t                     widm1_k;
	logic                      tk_done;
	logic [tsg_pkg::POS_W-1:0] up_x;
	logic [tsg_pkg::DIM_W-1:0] up_w;
	logic [tsg_pkg::DIM_W-1:0] up_h;

	always_comb begin
		wide_t um_lo;
		wide_t um_hi;

		wid     = tsg_pkg::eff_dim(width_q);
		wid_k   = wide_t'(wid);
		widm1_k = wid_k - wide_t'(1);

		tk_done = (line_q > tsg_pkg::DIM_W'(final_q)) || (cnt_q >= SCW'(MAX_SPANS));

		um_lo = wide_t'(bmin_q);
		if (um_lo < 0) begin
			um_lo = '0;
		end
		if (um_lo > widm1_k) begin
			um_lo = widm1_k;
		end
		um_hi = wide_t'(bmax_q);
		if (um_hi < 0) begin
			um_hi = '0;
		end
		if (um_hi > widm1_k) begin
			um_hi = widm1_k;
		end
		if (um_hi < um_lo) begin
			um_hi = um_lo;
		end

		up_x = um_lo[tsg_pkg::POS_W-1:0];
		up_w = tsg_pkg::DIM_W'(um_hi - um_lo + wide_t'(1));
		up_h = tsg_pkg::DIM_W'(final_q) - tsg_pkg::DIM_W'(first_q) + tsg_pkg::DIM_W'(1);
	end

	// ------------------------------------------------------------------
	// Edge setup. The left edge runs from the top vertex to the middle one
	// above the middle y and from the middle to the bottom vertex below it;
	// the right edge runs from top to bottom. The interpolation
	// xa + dx*(y-ya)/(yb-ya) truncates toward zero. Since the divisor is
	// positive and y-ya is not negative, the sign comes from dx alone, and
	// the magnitudes go through the unsigned divider. The quotient never
	// exceeds |dx|, so COORD_BITS+1 quotient bits are enough.
	// ------------------------------------------------------------------
	wide_t             mu_yk;
	logic              mu_below;
	coord_t            mu_xa;
	coord_t            mu_ya;
	coord_t            mu_xb;
	coord_t            mu_yb;
	logic signed [CB:0] mu_dx;
	logic [QW-1:0]     mu_mag;
	wide_t             mu_dy_k;
	wide_t             mu_dyy_k;
	logic [CB-1:0]     mu_dy;
	logic [CB-1:0]     mu_dyy;
	logic [PW-1:0]     mu_prod;

	always_comb begin
		mu_yk    = wide_t'(ywork_q);
		mu_below = mu_yk < wide_t'(y1_q);

		if (edge_q == EDGE_RIGHT) begin
			mu_xa = x0_q; mu_ya = y0_q; mu_xb = x2_q; mu_yb = y2_q;
		end else if (mu_below) begin
			mu_xa = x0_q; mu_ya = y0_q; mu_xb = x1_q; mu_yb = y1_q;
		end else begin
			mu_xa = x1_q; mu_ya = y1_q; mu_xb = x2_q; mu_yb = y2_q;
		end

		mu_dx    = (CB+1)'(mu_xb) - (CB+1)'(mu_xa);
		mu_mag   = mu_dx[CB] ? QW'(-mu_dx) : QW'(mu_dx);
		mu_dy_k  = wide_t'(mu_yb) - wide_t'(mu_ya);
		mu_dyy_k = mu_yk - wide_t'(mu_ya);
		mu_dy    = mu_dy_k[CB-1:0];
		mu_dyy   = mu_dyy_k[CB-1:0];
		mu_prod  = PW'(mu_mag) * PW'(mu_dyy);
	end

	// One restoring division step: the next dividend bit shifts into the
	// partial remainder and the quotient bit shifts into the low register.
	logic [CB:0] dv_t;
	logic [CB:0] dv_diff;
	logic        dv_ge;

	always_comb begin
		dv_t    = {rem_q, quo_q[QW-1]};
		dv_ge   = dv_t >= {1'b0, den_q};
		dv_diff = dv_t - {1'b0, den_q};
	end

	// Edge x from the start vertex and the signed quotient.
	xpos_t ad_q;
	xpos_t ad_x;

	always_comb begin
		ad_q = xpos_t'({1'b0, quo_q});
		ad_x = xpos_t'(xa_q) + (neg_q ? -ad_q : ad_q);
	end

	// ------------------------------------------------------------------
	// Line finish: order the left and right edges, drop lines off the frame
	// sideways, clip the rest to the frame width and grow the bounding box.
	// ------------------------------------------------------------------
	wide_t                     fn_lo;
	wide_t                     fn_hi;
	logic                      fn_vis;
	xpos_t                     fn_lo_x;
	xpos_t                     fn_hi_x;
	logic [tsg_pkg::DIM_W-1:0] fn_w;

	always_comb begin
		if (lx_q > rx_q) begin
			fn_lo = wide_t'(rx_q);
			fn_hi = wide_t'(lx_q);
		end else begin
			fn_lo = wide_t'(lx_q);
			fn_hi = wide_t'(rx_q);
		end
		fn_vis = !((fn_hi < 0) || (fn_lo >= wid_k));
		if (fn_lo < 0) begin
			fn_lo = '0;
		end
		if (fn_hi >= wid_k) begin
			fn_hi = widm1_k;
		end
		fn_lo_x = xpos_t'(fn_lo);
		fn_hi_x = xpos_t'(fn_hi);
		fn_w    = tsg_pkg::DIM_W'(fn_hi - fn_lo + wide_t'(1));
	end

	// ------------------------------------------------------------------
	// Sequencer, triangle state and output register.
	// A load finishes in its accept cycle. A tick on a walk that is over
	// goes straight to the emit state with the update rectangle. A tick on
	// a walk in progress runs the left edge, then the right edge, through
	// the multiply and divide steps, then finishes the line. The output
	// register takes the pending result as soon as it is free, so a new
	// request is taken while an earlier result still waits downstream.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			width_q     <= tsg_pkg::WIDTH_RESET;
			height_q    <= tsg_pkg::HEIGHT_RESET;
			x0_q        <= '0;
			x1_q        <= '0;
			x2_q        <= '0;
			y0_q        <= '0;
			y1_q        <= '0;
			y2_q        <= '0;
			color_q     <= '0;
			line_q      <= '0;
			first_q     <= '0;
			final_q     <= '0;
			cnt_q       <= '0;
			bmin_q      <= '0;
			bmax_q      <= '0;
			scan_q      <= 1'b0;
			ywork_q     <= '0;
			edge_q      <= EDGE_LEFT;
			xa_q        <= '0;
			den_q       <= '0;
			neg_q       <= 1'b0;
			rem_q       <= '0;
			quo_q       <= '0;
			div_cnt_q   <= '0;
			lx_q        <= '0;
			rx_q        <= '0;
			pend_q      <= '0;
			pend_kind_q <= tsg_pkg::KIND_SPAN;
			pend_last_q <= 1'b0;
			od_q        <= '0;
			okind_q     <= tsg_pkg::KIND_SPAN;
			olast_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					tsg_pkg::REG_FRAME_WIDTH:  width_q  <= cfg_data;
					tsg_pkg::REG_FRAME_HEIGHT: height_q <= cfg_data;
					default: ;
				endcase
			end

			// The output register loads the pending result while the sequencer
			// waits in the emit state and the register is free or being drained;
			// otherwise it only drops a result that was taken.
			if ((state_q == ST_EMIT) && (!out_valid_q || m_axis_tready)) begin
				od_q        <= pend_q;
				okind_q     <= pend_kind_q;
				olast_q     <= pend_last_q;
				out_valid_q <= 1'b1;
			end else if (out_valid_q && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid && s_axis_tready) begin
						if (s_axis_tuser == tsg_pkg::ACT_LOAD) begin
							if (ld_discard) begin
								scan_q <= 1'b0;
							end else begin
								x0_q    <= ld_x[0];
								x1_q    <= ld_x[1];
								x2_q    <= ld_x[2];
								y0_q    <= ld_y[0];
								y1_q    <= ld_y[1];
								y2_q    <= ld_y[2];
								color_q <= ld_c[0];
								first_q <= ld_first;
								final_q <= ld_final;
								line_q  <= tsg_pkg::DIM_W'(ld_first);
								cnt_q   <= '0;
								bmin_q  <= xpos_t'(ld_x[0]);
								bmax_q  <= xpos_t'(ld_x[0]);
								scan_q  <= 1'b1;
							end
						end else if (scan_q) begin
							if (tk_done) begin
								pend_q.pad        <= '0;
								pend_q.fill_color <= '0;
								pend_q.rect_x     <= up_x;
								pend_q.rect_y     <= first_q;
								pend_q.rect_w     <= up_w;
								pend_q.rect_h     <= up_h;
								pend_kind_q       <= tsg_pkg::KIND_UPDATE;
								pend_last_q       <= 1'b1;
								scan_q            <= 1'b0;
								state_q           <= ST_EMIT;
							end else begin
								ywork_q <= line_q[tsg_pkg::POS_W-1:0];
								line_q  <= line_q + tsg_pkg::DIM_W'(1);
								edge_q  <= EDGE_LEFT;
								state_q <= ST_MUL;
							end
						end
					end
				end

				ST_MUL: begin
					xa_q <= mu_xa;
					if (mu_dy == '0) begin
						// A flat edge gives its start x.
						neg_q   <= 1'b0;
						quo_q   <= '0;
						state_q <= ST_ADD;
					end else begin
						neg_q     <= mu_dx[CB];
						den_q     <= mu_dy;
						rem_q     <= mu_prod[PW-1:QW];
						quo_q     <= mu_prod[QW-1:0];
						div_cnt_q <= DIV_LAST;
						state_q   <= ST_DIV;
					end
				end

				ST_DIV: begin
					rem_q <= dv_ge ? dv_diff[CB-1:0] : dv_t[CB-1:0];
					quo_q <= {quo_q[QW-2:0], dv_ge};
					if (div_cnt_q == '0) begin
						state_q <= ST_ADD;
					end else begin
						div_cnt_q <= div_cnt_q - CNTW'(1);
					end
				end

				ST_ADD: begin
					if (edge_q == EDGE_LEFT) begin
						lx_q    <= ad_x;
						edge_q  <= EDGE_RIGHT;
						state_q <= ST_MUL;
					end else begin
						rx_q    <= ad_x;
						state_q <= ST_FIN;
					end
				end

				ST_FIN: begin
					if (fn_vis) begin
						if (fn_lo_x < bmin_q) begin
							bmin_q <= fn_lo_x;
						end
						if (fn_hi_x > bmax_q) begin
							bmax_q <= fn_hi_x;
						end
						cnt_q             <= cnt_q + SCW'(1);
						pend_q.pad        <= '0;
						pend_q.fill_color <= color_q;
						pend_q.rect_x     <= fn_lo[tsg_pkg::POS_W-1:0];
						pend_q.rect_y     <= ywork_q;
						pend_q.rect_w     <= fn_w;
						pend_q.rect_h     <= tsg_pkg::DIM_W'(1);
						pend_kind_q       <= tsg_pkg::KIND_SPAN;
						pend_last_q       <= 1'b0;
						state_q           <= ST_EMIT;
					end else begin
						state_q <= ST_IDLE;
					end
				end

				ST_EMIT: begin
					if (!out_valid_q || m_axis_tready) begin
						state_q <= ST_IDLE;
					end
				end

				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

### hdl/tsg_checker.sv
// ----------------------------------------------------------------------------
// Triangle span generator checker
// Port-level assertions on result shape and ordering, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tsg_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_axis_tready,
	input logic                           m_axis_tvalid,
	input logic                           m_axis_tready,
	input logic [tsg_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input logic                           m_axis_tuser,
	input logic                           m_axis_tlast
);

	tsg_pkg::out_data_t od;

	assign od = m_axis_tdata;

	`TSG_ASSERT(a_span_shape, (m_axis_tvalid && m_axis_tuser == tsg_pkg::KIND_SPAN) |-> (!m_axis_tlast && od.rect_h == 14'd1 && od.rect_w != '0), "span must be one line high, nonempty and not last")
	`TSG_ASSERT(a_update_shape, (m_axis_tvalid && m_axis_tuser == tsg_pkg::KIND_UPDATE) |-> (m_axis_tlast && od.fill_color == '0 && od.rect_w != '0 && od.rect_h != '0), "update rectangle must be last, colorless and nonempty")
	`TSG_ASSERT(a_result_after_work, $rose(m_axis_tvalid) |-> $past(!s_axis_tready), "a result appeared without a request being worked on")
	`TSG_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "stalled result changed")

endmodule

bind triangle_scanline_span_generator_top tsg_checker u_tsg_checker (.*);
